// ===== rtl/core/dws_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and command-word constants for the DDS waveform setup sequencer.
// No dependencies; every other file in rtl/core imports this package.
package dws_pkg;

    // Field widths.
    localparam int FREQ_W  = 27;
    localparam int SCALE_W = 28;
    localparam int SEL_W   = 2;
    localparam int MODE_W  = 2;
    localparam int PHASE_W = 12;
    localparam int WORD_W  = 16;
    localparam int TW_W    = 28;
    localparam int HALF_W  = 14;

    // Product and divider geometry. The divisor is 2^7 times the odd factor 78125,
    // so the product is shifted right by seven and multiplied by a 32-bit reciprocal
    // of the odd factor; that estimate of the quotient is low by at most one.
    localparam int PROD_W      = FREQ_W + SCALE_W;
    localparam int DIV_W       = 24;
    localparam int DIV_SHIFT   = 7;
    localparam int X_W         = PROD_W - DIV_SHIFT;
    localparam int XH_W        = X_W / 2;
    localparam int ODD_W       = 17;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 2 * XH_W;
    localparam int PP_W        = XH_W + RECIP_W;
    localparam int QE_W        = PP_W - XH_W;
    localparam int REM_W       = XH_W;

    // Tenths of a hertz per megahertz.
    localparam logic [DIV_W-1:0] DIVISOR = 24'd10_000_000;
    localparam logic [ODD_W-1:0] ODD_DIVISOR = 17'd78_125;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(ODD_DIVISOR));

    localparam logic [SCALE_W-1:0] SCALE_RESET = 28'd10_737_418;

    // Command words and tags.
    localparam logic [WORD_W-1:0] W_RESET     = 16'h0100;
    localparam logic [WORD_W-1:0] W_B28_RESET = 16'h2100;
    localparam logic [WORD_W-1:0] TAG_REG0    = 16'h4000;
    localparam logic [WORD_W-1:0] TAG_REG1    = 16'h8000;
    localparam logic [WORD_W-1:0] TAG_PHASE   = 16'hC000;
    localparam logic [WORD_W-1:0] W_TRIANGLE  = 16'h2002;
    localparam logic [WORD_W-1:0] W_SQUARE    = 16'h2028;
    localparam logic [WORD_W-1:0] W_SINE      = 16'h2000;

    // Register select and wave mode codes.
    localparam logic [SEL_W-1:0]  SEL_REG0      = 2'd0;
    localparam logic [SEL_W-1:0]  SEL_REG1      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SINE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQUARE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE     = 2'd3;

    // Request fields that ride along with the tuning word computation.
    typedef struct packed {
        logic [SEL_W-1:0]   sel;
        logic [MODE_W-1:0]  mode;
        logic [PHASE_W-1:0] phase;
    } ctrl_t;

    // Word being presented by the sequencer.
    typedef enum logic [2:0] {
        STEP_RESET,
        STEP_B28,
        STEP_LO,
        STEP_HI,
        STEP_PHASE,
        STEP_WAVE
    } step_t;

    function automatic logic [WORD_W-1:0] wave_word(input logic [MODE_W-1:0] mode);
        logic [WORD_W-1:0] w;
        unique case (mode)
            MODE_TRIANGLE: w = W_TRIANGLE;
            MODE_SINE:     w = W_SINE;
            MODE_SQUARE:   w = W_SQUARE;
            MODE_NONE:     w = W_SINE;
            default:       w = W_SINE;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/dws_mult.sv =====
`timescale 1ns / 1ps
// Input register and frequency-times-scale multiplier, two pipeline stages.
// Depends on dws_pkg.
module dws_mult
    import dws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [FREQ_W-1:0]   in_freq,
    input  ctrl_t               in_ctrl,
    input  logic [SCALE_W-1:0]  scale,
    output logic                prod_valid,
    output logic [PROD_W-1:0]   prod,
    output ctrl_t               prod_ctrl
);

    logic                a_valid_reg;
    logic [FREQ_W-1:0]   a_freq_reg;
    ctrl_t               a_ctrl_reg;
    logic                b_valid_reg;
    logic [PROD_W-1:0]   b_prod_reg;
    ctrl_t               b_ctrl_reg;
    logic [PROD_W-1:0]   b_prod_next;

    assign b_prod_next = PROD_W'(a_freq_reg) * PROD_W'(scale);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_freq_reg <= in_freq;
            a_ctrl_reg <= in_ctrl;
            b_prod_reg <= b_prod_next;
            b_ctrl_reg <= a_ctrl_reg;
        end
    end

    assign prod_valid = b_valid_reg;
    assign prod       = b_prod_reg;
    assign prod_ctrl  = b_ctrl_reg;

endmodule

// ===== rtl/core/dws_div.sv =====
`timescale 1ns / 1ps
// Division of the product by DIVISOR in four pipeline stages: a shift, a reciprocal
// multiplication and one correction step. Depends on dws_pkg.
module dws_div
    import dws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                prod_valid,
    input  logic [PROD_W-1:0]   prod,
    input  ctrl_t               prod_ctrl,
    output logic                tw_valid,
    output logic [TW_W-1:0]     tw,
    output ctrl_t               tw_ctrl
);

    logic [X_W-1:0]    x;
    logic [PP_W-1:0]   s1_pp_lo_next;
    logic [PP_W-1:0]   s1_pp_hi_next;
    logic              s1_valid_reg;
    logic [PP_W-1:0]   s1_pp_lo_reg;
    logic [PP_W-1:0]   s1_pp_hi_reg;
    logic [REM_W-1:0]  s1_xlo_reg;
    ctrl_t             s1_ctrl_reg;

    logic [PP_W-1:0]   s2_sum;
    logic [QE_W-1:0]   s2_qe_next;
    logic              s2_valid_reg;
    logic [QE_W-1:0]   s2_qe_reg;
    logic [REM_W-1:0]  s2_xlo_reg;
    ctrl_t             s2_ctrl_reg;

    logic [REM_W-1:0]  s3_qd_next;
    logic              s3_valid_reg;
    logic [REM_W-1:0]  s3_qd_reg;
    logic [TW_W-1:0]   s3_qe_reg;
    logic [REM_W-1:0]  s3_xlo_reg;
    ctrl_t             s3_ctrl_reg;
    logic [REM_W-1:0]  s3_rem;
    logic              s3_ge;

    logic [TW_W-1:0]   s4_tw_next;
    logic              s4_valid_reg;
    logic [TW_W-1:0]   s4_tw_reg;
    ctrl_t             s4_ctrl_reg;

    // Dividing by 2^7 first leaves a division by the odd factor alone.
    assign x = prod[PROD_W-1:DIV_SHIFT];

    assign s1_pp_lo_next = PP_W'(x[XH_W-1:0]) * PP_W'(RECIP);
    assign s1_pp_hi_next = PP_W'(x[X_W-1:XH_W]) * PP_W'(RECIP);

    // Only the bits of x * RECIP above RECIP_SHIFT are needed for the estimate.
    assign s2_sum     = s1_pp_hi_reg + PP_W'(s1_pp_lo_reg[PP_W-1:XH_W]);
    assign s2_qe_next = s2_sum[PP_W-1:XH_W];

    // The true remainder is below twice the odd factor, so its low bits suffice.
    assign s3_qd_next = s2_qe_reg[REM_W-1:0] * REM_W'(ODD_DIVISOR);
    assign s3_rem     = s3_xlo_reg - s3_qd_reg;
    assign s3_ge      = (s3_rem >= REM_W'(ODD_DIVISOR));
    assign s4_tw_next = s3_qe_reg + TW_W'(s3_ge);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= prod_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pp_lo_reg <= s1_pp_lo_next;
            s1_pp_hi_reg <= s1_pp_hi_next;
            s1_xlo_reg   <= x[REM_W-1:0];
            s1_ctrl_reg  <= prod_ctrl;
            s2_qe_reg    <= s2_qe_next;
            s2_xlo_reg   <= s1_xlo_reg;
            s2_ctrl_reg  <= s1_ctrl_reg;
            s3_qd_reg    <= s3_qd_next;
            s3_qe_reg    <= s2_qe_reg[TW_W-1:0];
            s3_xlo_reg   <= s2_xlo_reg;
            s3_ctrl_reg  <= s2_ctrl_reg;
            s4_tw_reg    <= s4_tw_next;
            s4_ctrl_reg  <= s3_ctrl_reg;
        end
    end

    assign tw_valid = s4_valid_reg;
    assign tw       = s4_tw_reg;
    assign tw_ctrl  = s4_ctrl_reg;

    // The reciprocal estimate is never more than one below the true quotient.
    a_rem_below_twice_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_rem < REM_W'({ODD_DIVISOR, 1'b0})))
        else $error("divider remainder out of range");

    // Valid bits are always known once out of reset.
    a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg}))
        else $error("divider valid bit unknown");

endmodule

// ===== rtl/core/dws_seq.sv =====
`timescale 1ns / 1ps
// Command word sequencer: holds one computed request and presents its words
// one per cycle through an output register unless stalled. Depends on dws_pkg.
module dws_seq
    import dws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tw_valid,
    input  logic [TW_W-1:0]     tw,
    input  ctrl_t               tw_ctrl,
    output logic                take,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [WORD_W-1:0]   control_word,
    output logic                last_word
);

    step_t              step_reg;
    step_t              step_next;
    step_t              step_after;
    logic               busy_reg;
    logic               busy_next;
    logic [TW_W-1:0]    hold_tw_reg;
    ctrl_t              hold_ctrl_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  control_word_reg;
    logic               last_word_reg;

    logic               advance;
    logic               sel_ok;
    logic               mode_ok;
    logic [WORD_W-1:0]  tag;
    logic [WORD_W-1:0]  cur_word;
    logic               cur_last;

    // A word moves into the output register whenever that register is empty or
    // its current word is transferred in this cycle.
    assign advance = busy_reg && (!out_valid_reg || !out_stall);
    assign take    = tw_valid && (!busy_reg || (advance && cur_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_comb
    begin
        sel_ok  = (hold_ctrl_reg.sel == SEL_REG0) || (hold_ctrl_reg.sel == SEL_REG1);
        mode_ok = (hold_ctrl_reg.mode != MODE_NONE);
        tag     = (hold_ctrl_reg.sel == SEL_REG0) ? TAG_REG0 : TAG_REG1;

        unique case (step_reg)
            STEP_RESET:
            begin
                cur_word   = W_RESET;
                cur_last   = 1'b0;
                step_after = STEP_B28;
            end
            STEP_B28:
            begin
                cur_word   = W_B28_RESET;
                cur_last   = !sel_ok && !mode_ok;
                step_after = sel_ok ? STEP_LO : STEP_WAVE;
            end
            STEP_LO:
            begin
                cur_word   = tag | {{(WORD_W-HALF_W){1'b0}}, hold_tw_reg[HALF_W-1:0]};
                cur_last   = 1'b0;
                step_after = STEP_HI;
            end
            STEP_HI:
            begin
                cur_word   = tag | {{(WORD_W-HALF_W){1'b0}}, hold_tw_reg[TW_W-1:HALF_W]};
                cur_last   = 1'b0;
                step_after = STEP_PHASE;
            end
            STEP_PHASE:
            begin
                cur_word   = TAG_PHASE | {{(WORD_W-PHASE_W){1'b0}}, hold_ctrl_reg.phase};
                cur_last   = !mode_ok;
                step_after = STEP_WAVE;
            end
            STEP_WAVE:
            begin
                cur_word   = wave_word(hold_ctrl_reg.mode);
                cur_last   = 1'b1;
                step_after = STEP_RESET;
            end
            default:
            begin
                cur_word   = W_RESET;
                cur_last   = 1'b1;
                step_after = STEP_RESET;
            end
        endcase

        step_next = step_reg;
        busy_next = busy_reg;
        if (take)
        begin
            step_next = STEP_RESET;
            busy_next = 1'b1;
        end
        else if (advance)
        begin
            step_next = step_after;
            busy_next = !cur_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_tw_reg   <= tw;
            hold_ctrl_reg <= tw_ctrl;
        end
        if (advance)
        begin
            control_word_reg <= cur_word;
            last_word_reg    <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign control_word = control_word_reg;
    assign last_word    = last_word_reg;

    // The register words are only reached for a valid select.
    a_reg_words_need_select: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (step_reg == STEP_LO || step_reg == STEP_HI || step_reg == STEP_PHASE)
        |-> (hold_ctrl_reg.sel == SEL_REG0 || hold_ctrl_reg.sel == SEL_REG1))
        else $error("register word issued for an invalid select");

    // The wave word is only reached when a mode word is requested.
    a_wave_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg == STEP_WAVE |-> hold_ctrl_reg.mode != MODE_NONE)
        else $error("wave word issued with no mode");

    // The word after a final word opens a new sequence.
    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && last_word_reg
        |=> !out_valid_reg || control_word_reg == W_RESET)
        else $error("sequence did not restart with the reset word");

    // Within a sequence the reset word never repeats.
    a_no_reset_midway: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !last_word_reg
        |=> !out_valid_reg || control_word_reg != W_RESET)
        else $error("reset word inside a sequence");

endmodule

// ===== rtl/core/dds_waveform_setup_sequencer.sv =====
`timescale 1ns / 1ps
// Top level of the DDS waveform setup sequencer: scale register, multiplier,
// divider pipeline and word sequencer. Depends on dws_pkg, dws_mult, dws_div, dws_seq.
//
// Usage:
//   The input channel takes one request per transfer (freq_decihz, freq_reg_select,
//   wave_mode, phase) on in_valid / in_stall. The output channel delivers the
//   request's command words one per transfer on out_valid / out_stall; last_word
//   marks the final word of each request (two to six words per request).
//   The tuning scale is written through cfg_we / cfg_wdata; the user must write it
//   only while the block is idle, as the block itself does not enforce this.
//   The first word of a request passes two multiplier stages, four divider stages,
//   one hold stage and the output register. Throughput: one word per cycle while
//   out_stall is low; a request occupies the sequencer until its last word enters
//   the output register, and the pipeline accepts a new request in any cycle in
//   which the sequencer is free to take the oldest one. The multiplier and divider
//   hold up to six requests in flight and the sequencer one more.
//   Reset clears all valid bits and the sequencer, and loads the scale register
//   with its default of 10737418. When the receiver stalls, the output word holds,
//   and once the sequencer's hold stage is full the whole pipeline stalls and
//   in_stall rises; nothing is lost or repeated.
module dds_waveform_setup_sequencer
    import dws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [SCALE_W-1:0]  cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FREQ_W-1:0]   freq_decihz,
    input  logic [SEL_W-1:0]    freq_reg_select,
    input  logic [MODE_W-1:0]   wave_mode,
    input  logic [PHASE_W-1:0]  phase,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [WORD_W-1:0]   control_word,
    output logic                last_word
);

    logic [SCALE_W-1:0]  scale_reg;
    ctrl_t               in_ctrl;
    logic                pipe_en;
    logic                prod_valid;
    logic [PROD_W-1:0]   prod;
    ctrl_t               prod_ctrl;
    logic                tw_valid;
    logic [TW_W-1:0]     tw;
    ctrl_t               tw_ctrl;
    logic                take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    assign in_ctrl.sel   = freq_reg_select;
    assign in_ctrl.mode  = wave_mode;
    assign in_ctrl.phase = phase;

    // The pipeline moves as one; it halts only while a finished request waits
    // at the divider output for the sequencer.
    assign pipe_en  = !tw_valid || take;
    assign in_stall = !pipe_en;

    dws_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .in_valid   (in_valid),
        .in_freq    (freq_decihz),
        .in_ctrl    (in_ctrl),
        .scale      (scale_reg),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_ctrl  (prod_ctrl)
    );

    dws_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_ctrl  (prod_ctrl),
        .tw_valid   (tw_valid),
        .tw         (tw),
        .tw_ctrl    (tw_ctrl)
    );

    dws_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .tw_valid     (tw_valid),
        .tw           (tw),
        .tw_ctrl      (tw_ctrl),
        .take         (take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .control_word (control_word),
        .last_word    (last_word)
    );

endmodule
